[hw/rtl/ndt_pkg.sv]
// ndt_pkg: types, codes and constants shared by the notify debounce/throttle block
// used by ndt_step, ndt_cell and notify_debounce_throttle; depends on nothing
package ndt_pkg;

  localparam int NUM_CONTROLS_DEF = 64;
  localparam int IDX_W            = 6;
  localparam int VAL_W            = 32;
  localparam int IVL_W            = 16;
  localparam int POL_W            = 2;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;

  localparam logic [IVL_W-1:0] SINCE_MAX = '1;
  localparam logic [IVL_W-1:0] TIMER_MIN = IVL_W'(1);

  typedef enum logic [POL_W-1:0] {
    POL_IMMEDIATE = 2'd0,
    POL_DEBOUNCE  = 2'd1,
    POL_THROTTLE  = 2'd2
  } ndt_policy_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOGGLE_POLICY   = 2'd0,
    CFG_TOGGLE_INTERVAL = 2'd1,
    CFG_CONT_POLICY     = 2'd2,
    CFG_CONT_INTERVAL   = 2'd3
  } ndt_cfg_idx_t;

  typedef enum logic {
    CMD_CHANGE = 1'b0,
    CMD_TICK   = 1'b1
  } ndt_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FLUSH
  } ndt_state_t;

  // request payload
  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] control_index;
    logic [VAL_W-1:0] value;
    logic             category;
    logic             has_override;
    logic [POL_W-1:0] override_policy;
    logic [IVL_W-1:0] override_interval_ms;
  } ndt_in_t;

  // result payload
  typedef struct packed {
    logic [IDX_W-1:0] out_index;
    logic [VAL_W-1:0] out_value;
    logic             last_of_run;
  } ndt_out_t;

  // per-control state held in one ring cell
  typedef struct packed {
    logic [IVL_W-1:0] timer;
    logic             is_throttle;
    logic [IVL_W-1:0] since_sent;
    logic             sent_ever;
    logic [VAL_W-1:0] value;
  } ndt_entry_t;

  // request being swept through the ring, policy already resolved
  typedef struct packed {
    logic             is_tick;
    logic [POL_W-1:0] policy;
    logic [IVL_W-1:0] interval;
    logic [VAL_W-1:0] value;
  } ndt_job_t;

endpackage

[hw/rtl/ndt_stream_if.sv]
// ndt_stream_if: valid/ready channel carrying one payload of type T
// depends on nothing; the payload type is given at instantiation
interface ndt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/ndt_step.sv]
// ndt_step: update of the control entry at the head of the ring
// tick aging/expiry and change-request policy handling; depends on ndt_pkg
module ndt_step (
  input  ndt_pkg::ndt_entry_t        head,
  input  ndt_pkg::ndt_job_t          job,
  input  logic                       hit,
  output ndt_pkg::ndt_entry_t        updated,
  output logic                       emit,
  output logic [ndt_pkg::VAL_W-1:0]  emit_value
);
  import ndt_pkg::*;

  logic [IVL_W-1:0] remaining;

  // ticks still to wait before a trailing throttle send
  assign remaining = job.interval - head.since_sent;

  always_comb begin
    updated    = head;
    emit       = 1'b0;
    emit_value = head.value;
    if (job.is_tick) begin
      // age the elapsed count first, then count down the pending timer
      if (head.since_sent != SINCE_MAX) begin
        updated.since_sent = head.since_sent + TIMER_MIN;
      end
      if (head.timer != '0) begin
        updated.timer = head.timer - TIMER_MIN;
        if (head.timer == TIMER_MIN) begin
          emit = 1'b1;
          if (head.is_throttle) begin
            updated.since_sent = '0;
            updated.sent_ever  = 1'b1;
          end
          updated.is_throttle = 1'b0;
        end
      end
    end else if (hit) begin
      unique case (job.policy)
        POL_DEBOUNCE: begin
          updated.value       = job.value;
          updated.is_throttle = 1'b0;
          updated.timer       = (job.interval == '0) ? TIMER_MIN : job.interval;
        end
        POL_THROTTLE: begin
          if (!head.sent_ever || head.since_sent >= job.interval) begin
            // send now; only a pending throttle send is dropped
            emit               = 1'b1;
            emit_value         = job.value;
            updated.since_sent = '0;
            updated.sent_ever  = 1'b1;
            if (head.is_throttle) begin
              updated.timer       = '0;
              updated.is_throttle = 1'b0;
            end
          end else begin
            updated.value       = job.value;
            updated.is_throttle = 1'b1;
            updated.timer       = (remaining == '0) ? TIMER_MIN : remaining;
          end
        end
        default: begin
          // immediate, and the unused policy code
          emit       = 1'b1;
          emit_value = job.value;
        end
      endcase
    end
  end

endmodule

[hw/rtl/ndt_cell.sv]
// ndt_cell: one ring cell holding the state of one control
// loads its neighbor's entry whenever the ring shifts; depends on ndt_pkg
module ndt_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  ndt_pkg::ndt_entry_t d,
  output ndt_pkg::ndt_entry_t q
);
  import ndt_pkg::*;

  // timer and throttle bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      q.timer       <= '0;
      q.is_throttle <= 1'b0;
      q.since_sent  <= '0;
      q.sent_ever   <= 1'b0;
    end else if (shift) begin
      q.timer       <= d.timer;
      q.is_throttle <= d.is_throttle;
      q.since_sent  <= d.since_sent;
      q.sent_ever   <= d.sent_ever;
    end
  end

  // pending value word, meaningful only once written
  always_ff @(posedge clk) begin
    if (shift) begin
      q.value <= d.value;
    end
  end

endmodule

[hw/rtl/notify_debounce_throttle.sv]
// notify_debounce_throttle: per-control notification rate limiter
// channels: req (sink, payload ndt_in_t) carries value changes and ticks; rsp (source,
// payload ndt_out_t) carries the values sent, last_of_run set on the final result of a
// request. Both are valid/ready; a request is taken on valid and ready high together.
// cfg_we/cfg_index/cfg_data write the four default policy/interval registers.
// The control state sits in a ring of NUM_CONTROLS cells that rotates once per
// request past a single update unit, so entries are visited in index order.
// req is taken only in the idle state, so a new request waits until the last one's
// accept, ring sweep and flush step are done, and longer when rsp stalls. Each result
// is held in a one-deep register until the next expiry or the flush step, so its last
// flag is known; the final result of a request is pushed to the result register at
// the flush step, earlier ones as the next expiry is found. When rsp stalls, the
// result register keeps its value and the ring stops at an expiry that finds a result
// already held, until the register frees; req is not taken again until the flush is
// done.
// Reset (rst, synchronous) clears all timers, elapsed counts and the four
// registers; no clearing pass is needed.
module notify_debounce_throttle #(
  parameter int NUM_CONTROLS = ndt_pkg::NUM_CONTROLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  ndt_stream_if.sink                      req,
  ndt_stream_if.source                    rsp,
  input  logic                            cfg_we,
  input  logic [ndt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ndt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ndt_pkg::*;

  localparam int STEP_W = (NUM_CONTROLS > 1) ? $clog2(NUM_CONTROLS) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_CONTROLS - 1);

  // configuration registers
  logic [POL_W-1:0] toggle_policy;
  logic [IVL_W-1:0] toggle_interval_ms;
  logic [POL_W-1:0] continuous_policy;
  logic [IVL_W-1:0] continuous_interval_ms;

  ndt_state_t       state, state_next;
  ndt_job_t         job;
  logic [IDX_W-1:0] job_index;
  logic [STEP_W-1:0] step;

  logic             hold_valid;
  logic [IDX_W-1:0] hold_index;
  logic [VAL_W-1:0] hold_value;

  logic             out_valid;
  ndt_out_t         out_data;
  logic             out_free;

  logic             advance, push, push_last, hold_load, hold_clear;
  logic             hit, emit;
  logic [VAL_W-1:0] emit_value;
  ndt_in_t          in_data;

  ndt_entry_t       ring_q [NUM_CONTROLS];
  ndt_entry_t       updated;

  assign in_data   = req.data;
  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;
  assign out_free  = !out_valid || rsp.ready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      toggle_policy          <= '0;
      toggle_interval_ms     <= '0;
      continuous_policy      <= '0;
      continuous_interval_ms <= '0;
    end else if (cfg_we) begin
      unique case (ndt_cfg_idx_t'(cfg_index))
        CFG_TOGGLE_POLICY:   toggle_policy          <= cfg_data[POL_W-1:0];
        CFG_TOGGLE_INTERVAL: toggle_interval_ms     <= cfg_data[IVL_W-1:0];
        CFG_CONT_POLICY:     continuous_policy      <= cfg_data[POL_W-1:0];
        CFG_CONT_INTERVAL:   continuous_interval_ms <= cfg_data[IVL_W-1:0];
      endcase
    end
  end

  // capture the request and resolve its policy and interval
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      job.is_tick <= (ndt_cmd_t'(in_data.command) == CMD_TICK);
      job.value   <= in_data.value;
      job_index   <= in_data.control_index;
      if (in_data.has_override) begin
        job.policy   <= in_data.override_policy;
        job.interval <= in_data.override_interval_ms;
      end else if (in_data.category) begin
        job.policy   <= continuous_policy;
        job.interval <= continuous_interval_ms;
      end else begin
        job.policy   <= toggle_policy;
        job.interval <= toggle_interval_ms;
      end
    end
  end

  // head of the ring holds entry number step
  assign hit = !job.is_tick && (IDX_W'(step) == job_index);

  ndt_step u_step (
    .head       (ring_q[0]),
    .job        (job),
    .hit        (hit),
    .updated    (updated),
    .emit       (emit),
    .emit_value (emit_value)
  );

  // ring of cells, updated head entry re-enters at the tail
  for (genvar i = 0; i < NUM_CONTROLS; i++) begin : g_ring
    if (i == NUM_CONTROLS - 1) begin : g_tail
      ndt_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (advance),
        .d     (updated),
        .q     (ring_q[i])
      );
    end else begin : g_body
      ndt_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (advance),
        .d     (ring_q[i+1]),
        .q     (ring_q[i])
      );
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and sweep control
  always_comb begin
    state_next = state;
    advance    = 1'b0;
    push       = 1'b0;
    push_last  = 1'b0;
    hold_load  = 1'b0;
    hold_clear = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        // a new result displaces the held one, which needs a free output
        if (!(emit && hold_valid && !out_free)) begin
          advance = 1'b1;
          if (emit) begin
            hold_load = 1'b1;
            push      = hold_valid;
          end
          if (step == STEP_LAST) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          hold_clear = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ring position
  always_ff @(posedge clk) begin
    if (rst || state == ST_IDLE) begin
      step <= '0;
    end else if (advance) begin
      step <= (step == STEP_LAST) ? '0 : step + STEP_W'(1);
    end
  end

  // one-deep hold for the newest result
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (hold_load) begin
      hold_valid <= 1'b1;
    end else if (hold_clear) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_load) begin
      hold_index <= IDX_W'(step);
      hold_value <= emit_value;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data.out_index   <= hold_index;
      out_data.out_value   <= hold_value;
      out_data.last_of_run <= push_last;
    end
  end

`ifndef SYNTHESIS
  a_hold_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !hold_valid)
    else $error("held result left over after a request");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_LAST)
    else $error("ring position past the last control");

  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && advance && step == STEP_LAST) |=> (state == ST_FLUSH))
    else $error("sweep did not end after a full rotation");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |-> !push)
    else $error("result register overwritten while stalled");
`endif

endmodule

[tb/notify_debounce_throttle_checker.sv]
// notify_debounce_throttle_checker: watches the request, result and register ports of the
// rate limiter, predicts the values sent and compares them in order
// depends on ndt_pkg and ndt_stream_if
module notify_debounce_throttle_checker #(
  parameter int NUM_CONTROLS = ndt_pkg::NUM_CONTROLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  ndt_stream_if                          req,
  ndt_stream_if                          rsp,
  input  logic                           cfg_we,
  input  logic [ndt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ndt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding
);
  import ndt_pkg::*;

  // default policy and interval per category
  logic [POL_W-1:0] toggle_pol, cont_pol;
  logic [IVL_W-1:0] toggle_ivl, cont_ivl;

  // per-control limiter state
  logic [VAL_W-1:0] held_value    [NUM_CONTROLS];
  logic [IVL_W-1:0] hold_timer    [NUM_CONTROLS];
  logic             hold_throttle [NUM_CONTROLS];
  logic [IVL_W-1:0] ticks_since   [NUM_CONTROLS];
  logic             throttled_once[NUM_CONTROLS];

  // sends still to come, oldest first
  ndt_out_t due_sends[$];

  ndt_out_t got, want;
  bit       bad;

  task automatic clear_limiter();
    toggle_pol = POL_IMMEDIATE;
    cont_pol   = POL_IMMEDIATE;
    toggle_ivl = '0;
    cont_ivl   = '0;
    for (int i = 0; i < NUM_CONTROLS; i++) begin
      held_value[i]     = '0;
      hold_timer[i]     = '0;
      hold_throttle[i]  = 1'b0;
      ticks_since[i]    = '0;
      throttled_once[i] = 1'b0;
    end
    due_sends.delete();
  endtask

  // works out the sends caused by one request and queues them
  task automatic advance_limiter(input ndt_in_t r);
    ndt_out_t         send;
    bit               have_send;
    logic [POL_W-1:0] pol;
    logic [IVL_W-1:0] ivl;
    logic [IVL_W-1:0] left;
    int               idx;
    have_send = 1'b0;
    send      = '0;
    if (r.command == CMD_TICK) begin
      // elapsed counts move first, saturating
      for (int i = 0; i < NUM_CONTROLS; i++)
        if (ticks_since[i] != SINCE_MAX) ticks_since[i]++;
      // expiries in index order, the last one flagged
      for (int i = 0; i < NUM_CONTROLS; i++) begin
        if (hold_timer[i] != '0) begin
          hold_timer[i]--;
          if (hold_timer[i] == '0) begin
            if (have_send) due_sends.insert(due_sends.size(), send);
            send.out_index   = IDX_W'(i);
            send.out_value   = held_value[i];
            send.last_of_run = 1'b0;
            have_send        = 1'b1;
            if (hold_throttle[i]) begin
              ticks_since[i]    = '0;
              throttled_once[i] = 1'b1;
            end
            hold_throttle[i] = 1'b0;
          end
        end
      end
      if (have_send) begin
        send.last_of_run = 1'b1;
        due_sends.insert(due_sends.size(), send);
      end
      return;
    end

    idx = int'(r.control_index);
    if (idx >= NUM_CONTROLS) return;
    if (r.has_override) begin
      pol = r.override_policy;
      ivl = r.override_interval_ms;
    end else if (r.category) begin
      pol = cont_pol;
      ivl = cont_ivl;
    end else begin
      pol = toggle_pol;
      ivl = toggle_ivl;
    end
    send.out_index   = r.control_index;
    send.out_value   = r.value;
    send.last_of_run = 1'b1;

    case (pol)
      POL_DEBOUNCE: begin
        // restart the quiet timer with the newest value
        held_value[idx]    = r.value;
        hold_throttle[idx] = 1'b0;
        hold_timer[idx]    = (ivl == '0) ? TIMER_MIN : ivl;
      end
      POL_THROTTLE: begin
        if (!throttled_once[idx] || ticks_since[idx] >= ivl) begin
          // send now, dropping only a trailing throttle send
          due_sends.insert(due_sends.size(), send);
          ticks_since[idx]    = '0;
          throttled_once[idx] = 1'b1;
          if (hold_throttle[idx]) begin
            hold_timer[idx]    = '0;
            hold_throttle[idx] = 1'b0;
          end
        end else begin
          // trailing send once the interval has run out
          left               = ivl - ticks_since[idx];
          held_value[idx]    = r.value;
          hold_throttle[idx] = 1'b1;
          hold_timer[idx]    = (left == '0) ? TIMER_MIN : left;
        end
      end
      // immediate, and the unused code
      default: due_sends.insert(due_sends.size(), send);
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_limiter();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOGGLE_POLICY:   toggle_pol = cfg_data[POL_W-1:0];
          CFG_TOGGLE_INTERVAL: toggle_ivl = cfg_data[IVL_W-1:0];
          CFG_CONT_POLICY:     cont_pol   = cfg_data[POL_W-1:0];
          CFG_CONT_INTERVAL:   cont_ivl   = cfg_data[IVL_W-1:0];
          default: ;
        endcase
      end

      // compare each result with the oldest expected send
      if (rsp.valid && rsp.ready) begin
        got = rsp.data;
        if (due_sends.size() == 0) begin
          $display("%0t: unexpected send index %0d value %h last %0b", $time,
                   got.out_index, got.out_value, got.last_of_run);
          mismatches <= mismatches + 1;
        end else begin
          want = due_sends.pop_front();
          bad  = 1'b0;
          if (got.out_index !== want.out_index) begin
            $display("%0t: out_index expected %0d got %0d", $time,
                     want.out_index, got.out_index);
            bad = 1'b1;
          end
          if (got.out_value !== want.out_value) begin
            $display("%0t: out_value expected %h got %h", $time,
                     want.out_value, got.out_value);
            bad = 1'b1;
          end
          if (got.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %0b got %0b", $time,
                     want.last_of_run, got.last_of_run);
            bad = 1'b1;
          end
          if (bad) mismatches <= mismatches + 1;
        end
      end

      // predict on every accepted request
      if (req.valid && req.ready) advance_limiter(req.data);
    end
    outstanding <= due_sends.size();
  end

endmodule

[tb/notify_debounce_throttle_tb.sv]
// notify_debounce_throttle_tb: drives changes, ticks and register writes into the rate
// limiter with random idling on both channels; the checker module does the comparing
// depends on ndt_pkg, ndt_stream_if, notify_debounce_throttle and its checker
module notify_debounce_throttle_tb;
  import ndt_pkg::*;

  localparam int               NUM_CONTROLS    = NUM_CONTROLS_DEF;
  localparam int               SWEEP_CYCLES    = NUM_CONTROLS + 2;
  localparam int               HOLD_OFF_CYCLES = 1500;
  localparam int               WATCHDOG_LIMIT  = 10000;
  localparam int               PHASE_ITEMS     = 26;
  localparam int               SQUEEZE_AFTER   = 25;
  localparam logic [POL_W-1:0] POL_SPARE       = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;
  int                    sends_taken = 0;
  int                    quiet_cycles = 0;
  bit                    calm_sender = 1'b0;

  ndt_stream_if #(.T(ndt_in_t))  req ();
  ndt_stream_if #(.T(ndt_out_t)) rsp ();

  notify_debounce_throttle #(.NUM_CONTROLS(NUM_CONTROLS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  notify_debounce_throttle_checker #(.NUM_CONTROLS(NUM_CONTROLS)) sends_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  // idle length: mostly none or short, now and then long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(6, 60);
  endfunction

  function automatic ndt_in_t change_item(input int idx, input logic [VAL_W-1:0] val,
                                          input bit cat, input bit ovr,
                                          input logic [POL_W-1:0] pol,
                                          input logic [IVL_W-1:0] ivl);
    ndt_in_t r;
    r                      = '0;
    r.command              = CMD_CHANGE;
    r.control_index        = IDX_W'(idx);
    r.value                = val;
    r.category             = cat;
    r.has_override         = ovr;
    r.override_policy      = pol;
    r.override_interval_ms = ivl;
    return r;
  endfunction

  function automatic ndt_in_t tick_item();
    ndt_in_t r;
    r         = '0;
    r.command = CMD_TICK;
    return r;
  endfunction

  // mostly a handful of controls with short intervals so the timers interact
  function automatic ndt_in_t random_request();
    ndt_in_t r;
    r.command              = CMD_CHANGE;
    r.control_index        = IDX_W'($urandom);
    r.value                = $urandom;
    r.category             = 1'($urandom_range(0, 1));
    r.has_override         = ($urandom_range(0, 2) == 0);
    r.override_policy      = POL_W'($urandom_range(0, 2));
    r.override_interval_ms = IVL_W'($urandom_range(0, 6));
    if ($urandom_range(0, 99) < 35) begin
      // tick, other fields left as noise
      r.command = CMD_TICK;
      return r;
    end
    if ($urandom_range(0, 7) != 0) r.control_index = IDX_W'($urandom_range(0, 5));
    case ($urandom_range(0, 9))
      0: r.override_interval_ms = IVL_W'($urandom);
      1: r.override_interval_ms = '1;
      default: ;
    endcase
    return r;
  endfunction

  // offer one request and hold it until taken
  task automatic post(input ndt_in_t item);
    int gap;
    gap = calm_sender ? 0 : pick_idle();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data  <= item;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // wait for all sends, then for a sweep that may give none
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SWEEP_CYCLES + 4) @(posedge clk);
  endtask

  task automatic program_defaults(input logic [POL_W-1:0] tog_pol,
                                  input logic [IVL_W-1:0] tog_ivl,
                                  input logic [POL_W-1:0] con_pol,
                                  input logic [IVL_W-1:0] con_ivl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TOGGLE_POLICY;
    cfg_data  <= CFG_DATA_W'(tog_pol);
    @(posedge clk);
    cfg_index <= CFG_TOGGLE_INTERVAL;
    cfg_data  <= CFG_DATA_W'(tog_ivl);
    @(posedge clk);
    cfg_index <= CFG_CONT_POLICY;
    cfg_data  <= CFG_DATA_W'(con_pol);
    @(posedge clk);
    cfg_index <= CFG_CONT_INTERVAL;
    cfg_data  <= CFG_DATA_W'(con_ivl);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // count results taken, for the long hold-off
  always @(posedge clk)
    if (rsp.valid && rsp.ready) sends_taken <= sends_taken + 1;

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** notify_debounce_throttle: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off once results flow
  initial begin
    int  stall;
    bit  squeezed;
    squeezed = 1'b0;
    rsp.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (!squeezed && sends_taken >= SQUEEZE_AFTER) begin
        squeezed = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      stall = pick_idle();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // request side and verdict
  initial begin
    rst       <= 1'b1;
    req.valid <= 1'b0;
    req.data  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_TOGGLE_POLICY;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults send at once, spare policy code acts as immediate
    post(change_item(0, 32'h0000_0000, 1'b0, 1'b0, POL_IMMEDIATE, '0));
    post(change_item(63, 32'hFFFF_FFFF, 1'b1, 1'b0, POL_IMMEDIATE, '0));
    post(change_item(5, 32'hA5A5_A5A5, 1'b0, 1'b1, POL_SPARE, '1));
    // debounce: zero interval, restart, several expiries in one tick
    post(change_item(1, 32'h0000_0011, 1'b1, 1'b1, POL_DEBOUNCE, '0));
    post(change_item(2, 32'h0000_0022, 1'b0, 1'b1, POL_DEBOUNCE, 16'd2));
    post(change_item(2, 32'h0000_0023, 1'b0, 1'b1, POL_DEBOUNCE, 16'd2));
    post(change_item(63, 32'h5A5A_5A5A, 1'b0, 1'b1, POL_DEBOUNCE, 16'd1));
    post(tick_item());
    post(tick_item());
    post(tick_item());
    // throttle then debounce on one control; a throttle send keeps the debounce
    post(change_item(3, 32'h0000_0031, 1'b0, 1'b1, POL_THROTTLE, 16'd3));
    post(change_item(3, 32'h0000_0032, 1'b0, 1'b1, POL_THROTTLE, 16'd3));
    post(change_item(3, 32'h0000_0033, 1'b0, 1'b1, POL_DEBOUNCE, 16'd2));
    post(change_item(3, 32'h0000_0034, 1'b0, 1'b1, POL_THROTTLE, 16'd0));
    post(tick_item());
    post(tick_item());
    // trailing throttle expiry restarts the count, a send at once cancels it
    post(change_item(4, 32'h0000_0041, 1'b1, 1'b1, POL_THROTTLE, 16'd2));
    post(change_item(4, 32'h0000_0042, 1'b1, 1'b1, POL_THROTTLE, 16'd2));
    post(tick_item());
    post(tick_item());
    post(change_item(4, 32'h0000_0043, 1'b1, 1'b1, POL_THROTTLE, 16'd2));
    post(change_item(4, 32'h0000_0044, 1'b1, 1'b1, POL_THROTTLE, 16'd0));
    post(tick_item());
    post(tick_item());
    // longest interval
    post(change_item(6, 32'h8000_0001, 1'b0, 1'b1, POL_THROTTLE, '1));
    post(change_item(6, 32'h7FFF_FFFE, 1'b0, 1'b1, POL_THROTTLE, '1));

    // random phases under different defaults
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      calm_sender = (phase == 1);
      case (phase)
        0: program_defaults(POL_DEBOUNCE, 16'd3, POL_THROTTLE, 16'd2);
        1: program_defaults(POL_THROTTLE, 16'd0, POL_DEBOUNCE, 16'hFFFF);
        2: program_defaults(POL_IMMEDIATE, 16'hFFFF, POL_THROTTLE, 16'd5);
        default: program_defaults(POL_W'($urandom_range(0, 2)),
                                  IVL_W'($urandom_range(0, 6)),
                                  POL_W'($urandom_range(0, 2)),
                                  IVL_W'($urandom_range(0, 6)));
      endcase
      repeat (PHASE_ITEMS) post(random_request());
    end

    // drain
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2 * SWEEP_CYCLES) @(posedge clk);
    if (outstanding != 0)
      $display("%0t: %0d expected sends never arrived", $time, outstanding);
    if (mismatches == 0 && outstanding == 0)
      $display("** notify_debounce_throttle: PASSED **");
    else
      $display("** notify_debounce_throttle: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ndt_pkg.sv
hw/rtl/ndt_stream_if.sv
hw/rtl/ndt_step.sv
hw/rtl/ndt_cell.sv
hw/rtl/notify_debounce_throttle.sv
tb/notify_debounce_throttle_checker.sv
tb/notify_debounce_throttle_tb.sv
